/* hdl/dnlc_pkg.sv */
// ----------------------------------------------------------------------------
// dnlc_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the directory name lookup cache.
// ----------------------------------------------------------------------------
package dnlc_pkg;

  localparam int ENTRIES_DEF    = 64;
  localparam int NAME_BYTES_DEF = 32;

  localparam logic [2:0] KIND_LOOKUP    = 3'd0;
  localparam logic [2:0] KIND_ENTER     = 3'd1;
  localparam logic [2:0] KIND_REMOVE    = 3'd2;
  localparam logic [2:0] KIND_PURGE_ID  = 3'd3;
  localparam logic [2:0] KIND_PURGE_SB  = 3'd4;
  localparam logic [2:0] KIND_PURGE_ALL = 3'd5;

  typedef struct packed {
    logic [15:0] dir;
    logic [15:0] tgt;
    logic [7:0]  sb;
  } meta_t;

  // commands from controller to datapath
  typedef struct packed {
    logic byte_we;
    logic op_start;
    logic op_end;
    logic init_step;
    logic scan_clr;
    logic scan_rd;
    logic scan_adv;
    logic found_ld;
    logic m_scan;
    logic head_rd;
    logic m_head;
    logic slot_wr;
    logic valid_clr_all;
    logic valid_clr;
    logic walk_start;
    logic walk_rd;
    logic walk_wr;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic init_done;
    logic ovf;
    logic hit_name;
    logic hit_id;
    logic hit_sb;
    logic scan_last;
    logic walk_stop;
  } st_t;

endpackage

/* hdl/directory_name_lookup_cache.sv */
// ----------------------------------------------------------------------------
// directory_name_lookup_cache
// Fully associative (directory, name) to node id cache with FIFO reuse.
// ----------------------------------------------------------------------------
// A name byte (last low) is taken while busy stays low, so bytes stream
// one per cycle. A last beat runs the operation: lookups, enters, removes
// and purges scan the slots, with a read and a compare per slot; an enter
// that misses adds a head read and a slot write; each slot freed by remove
// or purge adds a move-to-front walk over the reuse order memory. Disabled,
// over-long, purge-all and unknown operations finish without a scan. The
// result appears on done for one cycle as busy drops and cannot be held
// off. After reset the block is busy while it fills the reuse order.
// ----------------------------------------------------------------------------
module directory_name_lookup_cache
  import dnlc_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [7:0]  name_byte,
  input  logic        last,
  input  logic [15:0] dir_id,
  input  logic [15:0] target_id,
  input  logic [7:0]  target_sb,
  input  logic        caching_off,
  output logic        done,
  output logic        status,
  output logic [15:0] found_id
);

  cmd_t cmd;
  st_t  st;

  dnlc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .kind        (kind),
    .last        (last),
    .caching_off (caching_off),
    .st          (st),
    .cmd         (cmd),
    .busy        (busy),
    .done        (done),
    .status      (status)
  );

  dnlc_datapath #(
    .ENTRIES    (ENTRIES),
    .NAME_BYTES (NAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .name_byte (name_byte),
    .dir_id    (dir_id),
    .target_id (target_id),
    .target_sb (target_sb),
    .st        (st),
    .found_id  (found_id)
  );

endmodule

/* hdl/dnlc_ctrl.sv */
// ----------------------------------------------------------------------------
// dnlc_ctrl
// Operation sequencer: reset fill of the replacement order, slot scan,
// slot write, move-to-front walk and result strobe.
// ----------------------------------------------------------------------------
module dnlc_ctrl
  import dnlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] kind,
  input  logic       last,
  input  logic       caching_off,
  input  st_t        st,
  output cmd_t       cmd,
  output logic       busy,
  output logic       done,
  output logic       status
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_HEAD_RD, S_HEAD_WAIT,
    S_WRITE, S_WALK_RD, S_WALK_WR, S_FIN
  } state_t;

  state_t     state, state_next;
  logic [2:0] op, op_next;
  logic       fin_status, fin_status_next;
  logic       done_next, status_next;
  logic       purge_hit;

  assign busy = (state != S_IDLE);
  assign purge_hit = (op == KIND_PURGE_ID) ? st.hit_id : st.hit_sb;

  always_comb begin
    cmd             = '0;
    state_next      = state;
    op_next         = op;
    fin_status_next = fin_status;
    done_next       = 1'b0;
    status_next     = status;
    case (state)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (st.init_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (!last) begin
            cmd.byte_we = 1'b1;
          end else begin
            cmd.op_start = 1'b1;
            cmd.scan_clr = 1'b1;
            op_next      = kind;
            if (kind inside {KIND_LOOKUP, KIND_ENTER, KIND_REMOVE}) begin
              if (caching_off || st.ovf) begin
                fin_status_next = 1'b1;
                state_next      = S_FIN;
              end else begin
                state_next = S_SCAN_RD;
              end
            end else if (kind inside {KIND_PURGE_ID, KIND_PURGE_SB}) begin
              state_next = S_SCAN_RD;
            end else if (kind == KIND_PURGE_ALL) begin
              cmd.valid_clr_all = 1'b1;
              fin_status_next   = 1'b0;
              state_next        = S_FIN;
            end else begin
              fin_status_next = 1'b1;
              state_next      = S_FIN;
            end
          end
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (op == KIND_PURGE_ID || op == KIND_PURGE_SB) begin
          if (purge_hit) begin
            cmd.valid_clr  = 1'b1;
            cmd.walk_start = 1'b1;
            state_next     = S_WALK_RD;
          end else if (st.scan_last) begin
            fin_status_next = 1'b0;
            state_next      = S_FIN;
          end else begin
            cmd.scan_adv = 1'b1;
            state_next   = S_SCAN_RD;
          end
        end else if (st.hit_name) begin
          case (op)
            KIND_LOOKUP: begin
              cmd.found_ld    = 1'b1;
              fin_status_next = 1'b0;
              state_next      = S_FIN;
            end
            KIND_ENTER: begin
              cmd.m_scan = 1'b1;
              state_next = S_WRITE;
            end
            default: begin
              cmd.valid_clr  = 1'b1;
              cmd.walk_start = 1'b1;
              state_next     = S_WALK_RD;
            end
          endcase
        end else if (st.scan_last) begin
          if (op == KIND_ENTER) begin
            state_next = S_HEAD_RD;
          end else begin
            fin_status_next = 1'b1;
            state_next      = S_FIN;
          end
        end else begin
          cmd.scan_adv = 1'b1;
          state_next   = S_SCAN_RD;
        end
      end
      S_HEAD_RD: begin
        cmd.head_rd = 1'b1;
        state_next  = S_HEAD_WAIT;
      end
      S_HEAD_WAIT: begin
        cmd.m_head = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.slot_wr     = 1'b1;
        fin_status_next = 1'b0;
        state_next      = S_FIN;
      end
      S_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_next  = S_WALK_WR;
      end
      S_WALK_WR: begin
        cmd.walk_wr = 1'b1;
        if (st.walk_stop) begin
          if (op == KIND_REMOVE || st.scan_last) begin
            fin_status_next = 1'b0;
            state_next      = S_FIN;
          end else begin
            cmd.scan_adv = 1'b1;
            state_next   = S_SCAN_RD;
          end
        end else begin
          state_next = S_WALK_RD;
        end
      end
      S_FIN: begin
        cmd.op_end  = 1'b1;
        done_next   = 1'b1;
        status_next = fin_status;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    op         <= op_next;
    fin_status <= fin_status_next;
    status     <= status_next;
  end

endmodule

/* hdl/dnlc_datapath.sv */
// ----------------------------------------------------------------------------
// dnlc_datapath
// Incoming name buffer, slot tag and name memories, valid bits and the
// circular replacement-order memory with its move-to-front walk.
// ----------------------------------------------------------------------------
module dnlc_datapath
  import dnlc_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [7:0]  name_byte,
  input  logic [15:0] dir_id,
  input  logic [15:0] target_id,
  input  logic [7:0]  target_sb,
  output st_t         st,
  output logic [15:0] found_id
);

  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW  = $clog2(NAME_BYTES);
  localparam int NBW = NAME_BYTES * 8;

  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [IW:0]   ENT_W    = (IW + 1)'(ENTRIES);
  localparam logic [LW-1:0] LEN_MAX  = LW'(NAME_BYTES - 1);

  logic [NBW-1:0]   inc_name;
  logic [LW-1:0]    inc_len;
  logic             ovf;
  logic [15:0]      op_dir, op_tid;
  logic [7:0]       op_sb;

  logic [ENTRIES-1:0] valid;
  meta_t              meta_mem [ENTRIES];
  logic [NBW-1:0]     name_mem [ENTRIES];
  logic [IW-1:0]      order_mem [ENTRIES];
  meta_t              meta_rd;
  logic [NBW-1:0]     name_rd;
  logic [IW-1:0]      order_rd;

  logic [IW-1:0] scan_idx, m_idx, head, init_cnt, walk_i, carry;
  logic [IW:0]   walk_sum;
  logic [IW-1:0] walk_addr;
  logic          order_we, order_re;
  logic [IW-1:0] order_waddr, order_raddr, order_wdata;

  // incoming name and latched operands
  always_ff @(posedge clk) begin
    if (rst || cmd.op_end) begin
      inc_name <= '0;
      inc_len  <= '0;
      ovf      <= 1'b0;
    end else if (cmd.byte_we) begin
      if (inc_len < LEN_MAX) begin
        inc_name[8*inc_len +: 8] <= name_byte;
        inc_len                  <= inc_len + 1'b1;
      end else begin
        ovf <= 1'b1;
      end
    end
    if (cmd.op_start) begin
      op_dir <= dir_id;
      op_tid <= target_id;
      op_sb  <= target_sb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.valid_clr_all) begin
      valid <= '0;
    end else if (cmd.valid_clr) begin
      valid[scan_idx] <= 1'b0;
    end else if (cmd.slot_wr) begin
      valid[m_idx] <= 1'b1;
    end
  end

  // slot tag and name memories
  always_ff @(posedge clk) begin
    if (cmd.slot_wr) begin
      meta_mem[m_idx] <= '{dir: op_dir, tgt: op_tid, sb: op_sb};
      name_mem[m_idx] <= inc_name;
    end
    if (cmd.scan_rd) begin
      meta_rd <= meta_mem[scan_idx];
      name_rd <= name_mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      scan_idx <= '0;
    end else if (cmd.scan_adv) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (cmd.m_scan) begin
      m_idx <= scan_idx;
    end else if (cmd.m_head) begin
      m_idx <= order_rd;
    end
    if (cmd.op_start) begin
      found_id <= '0;
    end else if (cmd.found_ld) begin
      found_id <= meta_rd.tgt;
    end
  end

  // replacement order: circular buffer, head is the next slot to reuse
  assign walk_sum  = {1'b0, head} + {1'b0, walk_i};
  assign walk_addr = (walk_sum >= ENT_W) ? IW'(walk_sum - ENT_W) : walk_sum[IW-1:0];

  assign order_we    = cmd.init_step || cmd.walk_wr;
  assign order_waddr = cmd.init_step ? init_cnt : walk_addr;
  assign order_wdata = cmd.init_step ? init_cnt : carry;
  assign order_re    = cmd.head_rd || cmd.walk_rd;
  assign order_raddr = cmd.head_rd ? head : walk_addr;

  always_ff @(posedge clk) begin
    if (order_we) order_mem[order_waddr] <= order_wdata;
    if (order_re) order_rd <= order_mem[order_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      init_cnt <= '0;
    end else begin
      if (cmd.init_step) init_cnt <= init_cnt + 1'b1;
      // taking the head rotates the order: the old head becomes the tail
      if (cmd.m_head) head <= (head == LAST_IDX) ? '0 : head + 1'b1;
    end
    if (cmd.walk_start) begin
      walk_i <= '0;
      carry  <= scan_idx;
    end else if (cmd.walk_wr) begin
      walk_i <= walk_i + 1'b1;
      carry  <= order_rd;
    end
  end

  assign st.init_done = (init_cnt == LAST_IDX);
  assign st.ovf       = ovf;
  assign st.hit_name  = valid[scan_idx] && (meta_rd.dir == op_dir) && (name_rd == inc_name);
  assign st.hit_id    = valid[scan_idx] && ((meta_rd.tgt == op_tid) || (meta_rd.dir == op_tid));
  assign st.hit_sb    = valid[scan_idx] && (meta_rd.sb == op_sb);
  assign st.scan_last = (scan_idx == LAST_IDX);
  assign st.walk_stop = (order_rd == scan_idx) || (walk_i == LAST_IDX);

endmodule

/* hdl/dnlc_checker.sv */
// ----------------------------------------------------------------------------
// dnlc_port_checks
// Port-level checks on command acceptance and result strobes.
// ----------------------------------------------------------------------------
module dnlc_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        last,
  input logic        done,
  input logic        status,
  input logic [15:0] found_id
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  a_done_after_op: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result beat without a running operation");

  a_byte_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last) |=> !done)
    else $error("name byte produced a result");

  a_last_runs: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last) |=> busy)
    else $error("last beat did not start an operation");

  a_fail_no_id: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (found_id == 16'd0))
    else $error("failed operation returned a node id");

endmodule

bind directory_name_lookup_cache dnlc_port_checks u_dnlc_port_checks (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .last     (last),
  .done     (done),
  .status   (status),
  .found_id (found_id)
);

/* dv/dnlc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnlc_checker
// Watches the command and result channels of the name lookup cache, keeps a
// shadow of the slot store and reuse order, predicts each result and
// compares it with what the block returns.
// ----------------------------------------------------------------------------
module dnlc_checker
  import dnlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  kind,
  input  logic [7:0]  name_byte,
  input  logic        last,
  input  logic [15:0] dir_id,
  input  logic [15:0] target_id,
  input  logic [7:0]  target_sb,
  input  logic        caching_off,
  input  logic        done,
  input  logic        status,
  input  logic [15:0] found_id,
  output int          fails,
  output int          pending
);

  localparam int NSLOT = ENTRIES_DEF;
  localparam int NLEN  = NAME_BYTES_DEF;

  typedef struct {
    logic        status;
    logic [15:0] found;
  } answer_t;

  answer_t     answers_q[$];
  logic        sh_valid [NSLOT];
  logic [15:0] sh_dir   [NSLOT];
  logic [15:0] sh_tgt   [NSLOT];
  logic [7:0]  sh_sb    [NSLOT];
  logic [7:0]  sh_name  [NSLOT][NLEN];
  logic [5:0]  sh_order [NSLOT];
  logic [7:0]  cur_name [NLEN];
  int          cur_len;
  logic        cur_ovf;

  assign pending = answers_q.size();

  function automatic int match_slot(logic [15:0] d);
    bit same;
    for (int s = 0; s < NSLOT; s++) begin
      same = sh_valid[s] && sh_dir[s] == d;
      for (int b = 0; b < NLEN; b++) if (sh_name[s][b] != cur_name[b]) same = 0;
      if (same) return s;
    end
    return -1;
  endfunction

  // drop slot and move it to the head of the reuse order
  task automatic release_slot(int s);
    int p;
    p = 0;
    sh_valid[s] = 0;
    while (p < NSLOT - 1 && sh_order[p] != s) p++;
    for (int i = p; i > 0; i--) sh_order[i] = sh_order[i - 1];
    sh_order[0] = 6'(s);
  endtask

  function automatic int claim_head();
    logic [5:0] h;
    h = sh_order[0];
    for (int i = 0; i < NSLOT - 1; i++) sh_order[i] = sh_order[i + 1];
    sh_order[NSLOT - 1] = h;
    return h;
  endfunction

  task automatic apply_beat();
    answer_t a;
    int m;
    a.status = 1;
    a.found  = 0;
    if (!last) begin
      if (cur_len < NLEN - 1) begin
        cur_name[cur_len] = name_byte;
        cur_len++;
      end else cur_ovf = 1;
      return;
    end
    case (kind)
      KIND_LOOKUP, KIND_ENTER, KIND_REMOVE: begin
        if (!caching_off && !cur_ovf) begin
          m = match_slot(dir_id);
          if (kind == KIND_LOOKUP) begin
            if (m >= 0) begin
              a.status = 0;
              a.found  = sh_tgt[m];
            end
          end else if (kind == KIND_ENTER) begin
            if (m < 0) begin
              m = claim_head();
              sh_dir[m] = dir_id;
              for (int b = 0; b < NLEN; b++) sh_name[m][b] = cur_name[b];
              sh_valid[m] = 1;
            end
            sh_tgt[m] = target_id;
            sh_sb[m]  = target_sb;
            a.status  = 0;
          end else if (m >= 0) begin
            release_slot(m);
            a.status = 0;
          end
        end
      end
      KIND_PURGE_ID: begin
        for (int s = 0; s < NSLOT; s++)
          if (sh_valid[s] && (sh_tgt[s] == target_id || sh_dir[s] == target_id))
            release_slot(s);
        a.status = 0;
      end
      KIND_PURGE_SB: begin
        for (int s = 0; s < NSLOT; s++)
          if (sh_valid[s] && sh_sb[s] == target_sb) release_slot(s);
        a.status = 0;
      end
      KIND_PURGE_ALL: begin
        for (int s = 0; s < NSLOT; s++) sh_valid[s] = 0;
        a.status = 0;
      end
      default: ;
    endcase
    for (int b = 0; b < NLEN; b++) cur_name[b] = 0;
    cur_len = 0;
    cur_ovf = 0;
    answers_q.push_back(a);
  endtask

  always @(posedge clk) begin
    answer_t e;
    if (rst) begin
      answers_q.delete();
      fails   = 0;
      cur_len = 0;
      cur_ovf = 0;
      for (int s = 0; s < NSLOT; s++) begin
        sh_valid[s] = 0;
        sh_order[s] = 6'(s);
        sh_dir[s]   = 0;
        sh_tgt[s]   = 0;
        sh_sb[s]    = 0;
        for (int b = 0; b < NLEN; b++) sh_name[s][b] = 0;
      end
      for (int b = 0; b < NLEN; b++) cur_name[b] = 0;
    end else begin
      // results first: a beat accepted now cannot produce its result yet
      if (done) begin
        if (answers_q.size() == 0) begin
          $error("unexpected result beat: status %0d found_id %0d", status, found_id);
          fails++;
        end else begin
          e = answers_q.pop_front();
          if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            fails++;
          end
          if (found_id !== e.found) begin
            $error("found_id: expected %0d, got %0d", e.found, found_id);
            fails++;
          end
        end
      end
      if (start && !busy) apply_beat();
    end
  end

endmodule

/* dv/tb_directory_name_lookup_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_directory_name_lookup_cache
// Drives name bytes and operations into the lookup cache, directed cases
// first and then random traffic over small pools of names and directories,
// while the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_directory_name_lookup_cache;
  import dnlc_pkg::*;

  localparam int STALL_LIMIT = 60000;
  localparam int NAMES = 12;
  localparam int DIRS  = 8;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  kind;
  logic [7:0]  name_byte;
  logic        last;
  logic [15:0] dir_id;
  logic [15:0] target_id;
  logic [7:0]  target_sb;
  logic        caching_off;
  logic        done;
  logic        status;
  logic [15:0] found_id;
  int          fails;
  int          pending;
  int          stall_cycles;
  int          beats_sent;
  int          idle_pct;

  typedef logic [7:0] name_t[$];
  name_t       name_pool [NAMES];
  logic [15:0] dir_pool  [DIRS];
  logic [15:0] id_pool   [DIRS];

  directory_name_lookup_cache dut (.*);

  dnlc_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // hold one beat until the block takes it; called at a rising edge
  task automatic send_beat(logic [2:0] k, logic [7:0] b, logic l, logic [15:0] d,
                           logic [15:0] t, logic [7:0] s, logic o);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start       <= 1;
    kind        <= k;
    name_byte   <= b;
    last        <= l;
    dir_id      <= d;
    target_id   <= t;
    target_sb   <= s;
    caching_off <= o;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    beats_sent++;
  endtask

  task automatic run_op(logic [2:0] k, name_t nm, logic [15:0] d, logic [15:0] t,
                        logic [7:0] s, logic o, logic [7:0] term = 8'd0);
    foreach (nm[i]) send_beat(k, nm[i], 1'b0, d, t, s, o);
    send_beat(k, term, 1'b1, d, t, s, o);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic name_t random_name(int len);
    name_t n;
    for (int i = 0; i < len; i++) n.push_back(8'($urandom_range(255)));
    return n;
  endfunction

  initial begin
    name_t nm;
    name_t empty;
    int    r;
    int    ni;
    logic [2:0] k;
    rst = 1;
    start = 0;
    kind = KIND_LOOKUP;
    name_byte = 0;
    last = 0;
    dir_id = 1;
    target_id = 0;
    target_sb = 0;
    caching_off = 0;
    beats_sent = 0;
    idle_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed
    nm = '{8'h61};
    run_op(KIND_LOOKUP, nm, 16'd1, 16'd0, 8'd0, 0);
    run_op(KIND_ENTER, nm, 16'd1, 16'd5, 8'd3, 0);
    run_op(KIND_LOOKUP, nm, 16'd1, 16'd0, 8'd0, 0);
    run_op(KIND_ENTER, nm, 16'd1, 16'hFFFF, 8'hFF, 0);
    run_op(KIND_LOOKUP, nm, 16'd1, 16'd0, 8'd0, 0, 8'hA5);
    run_op(KIND_ENTER, empty, 16'hFFFF, 16'd0, 8'd7, 0);
    run_op(KIND_LOOKUP, empty, 16'hFFFF, 16'd0, 8'd0, 0);
    run_op(KIND_LOOKUP, nm, 16'd1, 16'd0, 8'd0, 1);
    run_op(KIND_ENTER, nm, 16'd2, 16'd9, 8'd7, 1);
    run_op(KIND_REMOVE, nm, 16'd2, 16'd0, 8'd0, 0);
    nm = '{8'h00, 8'h61};
    run_op(KIND_ENTER, nm, 16'd1, 16'd6, 8'd1, 0);
    run_op(KIND_LOOKUP, nm, 16'd1, 16'd0, 8'd0, 0);
    nm = random_name(31);
    run_op(KIND_ENTER, nm, 16'h8000, 16'h7FFF, 8'h80, 0);
    run_op(KIND_LOOKUP, nm, 16'h8000, 16'd0, 8'd0, 0);
    nm = random_name(33);
    run_op(KIND_ENTER, nm, 16'd3, 16'd4, 8'd1, 0);
    run_op(KIND_LOOKUP, nm, 16'd3, 16'd0, 8'd0, 0);
    nm = '{8'h61};
    run_op(KIND_REMOVE, nm, 16'd1, 16'd0, 8'd0, 0);
    run_op(KIND_PURGE_ID, empty, 16'd1, 16'd0, 8'd0, 0);
    run_op(KIND_PURGE_SB, empty, 16'd1, 16'd0, 8'h80, 1);
    run_op(KIND_LOOKUP, empty, 16'hFFFF, 16'd0, 8'd0, 0);
    run_op(KIND_PURGE_ALL, empty, 16'd1, 16'd0, 8'd0, 0);
    run_op(3'd6, nm, 16'd1, 16'd0, 8'd0, 0);
    run_op(3'd7, nm, 16'd1, 16'd0, 8'd0, 0);
    drain();

    for (int i = 0; i < NAMES; i++) name_pool[i] = random_name($urandom_range(0, 3));
    for (int i = 0; i < DIRS; i++) begin
      dir_pool[i] = 16'($urandom_range(1, 65535));
      id_pool[i]  = 16'($urandom_range(0, 65535));
    end
    dir_pool[0] = 16'hFFFF;
    dir_pool[1] = 16'd1;
    id_pool[0]  = 16'd0;
    id_pool[1]  = dir_pool[2];

    // random phases: sender idle 0, 58, 58 and 23 percent
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 3) ? 23 : 58;
      while (beats_sent < 40 + (ph + 1) * 130) begin
        r = $urandom_range(99);
        k = (r < 35) ? KIND_LOOKUP : (r < 70) ? KIND_ENTER : (r < 82) ? KIND_REMOVE :
            (r < 88) ? KIND_PURGE_ID : (r < 94) ? KIND_PURGE_SB :
            (r < 97) ? KIND_PURGE_ALL : 3'($urandom_range(6, 7));
        ni = $urandom_range(NAMES - 1);
        nm = ($urandom_range(99) < 3) ? random_name($urandom_range(31, 34)) : name_pool[ni];
        run_op(k, nm, dir_pool[$urandom_range(DIRS - 1)],
               ($urandom_range(3) == 0) ? 16'($urandom) : id_pool[$urandom_range(DIRS - 1)],
               8'($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(3)),
               $urandom_range(99) < 5, ($urandom_range(9) == 0) ? 8'($urandom) : 8'd0);
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
hdl/dnlc_pkg.sv
hdl/dnlc_ctrl.sv
hdl/dnlc_datapath.sv
hdl/directory_name_lookup_cache.sv
hdl/dnlc_checker.sv
dv/dnlc_checker.sv
dv/tb_directory_name_lookup_cache.sv
